// ----- hw/rtl/vdrs_pkg.sv -----
package vdrs_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;
  localparam int CORDIC_STEPS        = 20;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  typedef logic signed [47:0] ival_t;

  localparam ival_t LIM48 = 48'sh7FFF_FFFF_FFFF;

  localparam logic [30:0]        INV_TWO_PI_Q32 = 31'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;

  localparam logic signed [20:0] TWO_PI_Q16    = 21'sd411775;
  localparam logic [18:0]        HEADING_RESET = 19'd308831;
  localparam logic signed [31:0] LAT_RESET     = 32'sd547892536;
  localparam logic signed [32:0] LON_RESET     = -33'sd1968792205;
  localparam logic signed [33:0] DEG90_Q24     = 34'sd1509949440;
  localparam logic signed [33:0] DEG180_Q24    = 34'sd3019898880;
  localparam logic signed [33:0] DEG360_Q24    = 34'sd6039797760;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_COEFF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_YAW_INER = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUDDER_AREA  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_SCALE    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LON_SCALE    = 8'd7;

  // datapath operations in program order
  typedef enum logic [4:0] {
    OP_TRIG_RUD, OP_SQ, OP_T1, OP_FORCE, OP_YAWF, OP_RDRAG, OP_TORQ, OP_YACC,
    OP_YR, OP_DYAW, OP_DRAG, OP_THR, OP_SACC, OP_SN, OP_TRIG_HD, OP_NC, OP_DN,
    OP_LAT, OP_EC, OP_DE, OP_LON
  } op_t;

  typedef struct packed {
    op_t  op;
    logic mul_start;
    logic trig_start;
    logic load_in;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic trig_done;
  } dp_stat_t;

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/vdrs_mul.sv -----
module vdrs_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  vdrs_pkg::ival_t      a,
  input  vdrs_pkg::ival_t      b,
  input  logic                 sh32,
  output logic                 done,
  output vdrs_pkg::ival_t      p
);
  import vdrs_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND, M_SAT} mstate_t;

  localparam logic [79:0] LIM80 = {32'd0, LIM48};

  mstate_t      state_r, state_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [47:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic         neg_r, neg_nxt, sh32_r, sh32_nxt, done_r, done_nxt;
  logic [95:0]  acc_r, acc_nxt, lo2;
  logic [79:0]  q_r, q_nxt;
  logic [47:0]  mag;
  ival_t        p_r, p_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    neg_nxt   = neg_r;
    sh32_nxt  = sh32_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    p_nxt     = p_r;
    done_nxt  = 1'b0;
    lo2       = acc_r + (sh32_r ? 96'h8000_0000 : 96'h8000);
    mag       = (q_r > LIM80) ? LIM48 : q_r[47:0];
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          ma_nxt    = a[47] ? 48'(-a) : a;
          mb_nxt    = b[47] ? 48'(-b) : b;
          neg_nxt   = a[47] ^ b[47];
          sh32_nxt  = sh32;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = M_ACC;
        end
      end
      M_ACC: begin
        // one 16-bit digit of b per cycle, most significant first
        acc_nxt = {acc_r[79:0], 16'd0} + 96'(ma_r * mb_r[47:32]);
        mb_nxt  = {mb_r[31:0], 16'd0};
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) state_nxt = M_RND;
      end
      M_RND: begin
        q_nxt     = sh32_r ? {16'd0, lo2[95:32]} : lo2[95:16];
        state_nxt = M_SAT;
      end
      M_SAT: begin
        p_nxt     = neg_r ? ival_t'(-mag) : ival_t'(mag);
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= neg_nxt;
    sh32_r <= sh32_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    p_r    <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

  a_sym_sat: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (p_r >= -LIM48))
    else $error("product outside symmetric 48-bit range");
endmodule

// ----- hw/rtl/vdrs_cordic.sv -----
module vdrs_cordic #(
  parameter int TRIG_TABLE_BITS = vdrs_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [19:0]  angle,
  output logic                done,
  output logic signed [17:0]  sin_q,
  output logic signed [17:0]  cos_q
);
  import vdrs_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_PHASE, C_ROT, C_OUT} cstate_t;

  localparam logic [31:0] RND_HALF = 32'd1 << (31 - TRIG_TABLE_BITS);
  localparam logic [31:0] PH_MASK  = ~((32'd1 << (32 - TRIG_TABLE_BITS)) - 32'd1);

  cstate_t             state_r, state_nxt;
  logic signed [50:0]  p_r, p_nxt;
  logic signed [33:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, dx, dy;
  logic [4:0]          iter_r, iter_nxt;
  logic                flip_r, flip_nxt, done_r, done_nxt;
  logic signed [17:0]  sin_r, sin_nxt, cos_r, cos_nxt, s16, c16;
  logic [31:0]         ph, ph2;

  // Q2.30 to Q1.16 with clamp to one
  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd65536)       return 18'sd65536;
    else if (t < -34'sd65536) return -18'sd65536;
    else                      return t[17:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    iter_nxt  = iter_r;
    flip_nxt  = flip_r;
    sin_nxt   = sin_r;
    cos_nxt   = cos_r;
    done_nxt  = 1'b0;
    ph        = (p_r[47:16] + RND_HALF) & PH_MASK;
    ph2       = (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) ? ph - 32'h8000_0000 : ph;
    dx        = y_r >>> iter_r;
    dy        = x_r >>> iter_r;
    s16       = to_q16(y_r);
    c16       = to_q16(x_r);
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          p_nxt     = 51'(angle * $signed({1'b0, INV_TWO_PI_Q32}));
          state_nxt = C_PHASE;
        end
      end
      C_PHASE: begin
        flip_nxt  = (ph[31:30] == 2'd1 || ph[31:30] == 2'd2);
        z_nxt     = {{2{ph2[31]}}, ph2};
        x_nxt     = CORDIC_GAIN;
        y_nxt     = '0;
        iter_nxt  = '0;
        state_nxt = C_ROT;
      end
      C_ROT: begin
        if (!z_r[33]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - $signed({2'b00, atan_turn(iter_r)});
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + $signed({2'b00, atan_turn(iter_r)});
        end
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'(CORDIC_STEPS - 1)) state_nxt = C_OUT;
      end
      C_OUT: begin
        sin_nxt   = flip_r ? 18'(-s16) : s16;
        cos_nxt   = flip_r ? 18'(-c16) : c16;
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    p_r    <= p_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    iter_r <= iter_nxt;
    flip_r <= flip_nxt;
    sin_r  <= sin_nxt;
    cos_r  <= cos_nxt;
  end

  assign done  = done_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (sin_r <= 18'sd65536 && sin_r >= -18'sd65536
                && cos_r <= 18'sd65536 && cos_r >= -18'sd65536))
    else $error("trig result beyond unit range");
endmodule

// ----- hw/rtl/vdrs_dp.sv -----
module vdrs_dp #(
  parameter int TRIG_TABLE_BITS = vdrs_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [vdrs_pkg::IN_DATA_W-1:0]       in_data,
  input  logic                                 cfg_we,
  input  logic [vdrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vdrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  vdrs_pkg::dp_cmd_t                    cmd,
  output vdrs_pkg::dp_stat_t                   stat,
  output logic [vdrs_pkg::OUT_DATA_W-1:0]      out_data
);
  import vdrs_pkg::*;

  // configuration
  logic [23:0] drag_r, thrust_r, area_r, lever_r;
  logic [31:0] inv_m_r, inv_i_r;
  logic [39:0] lat_sc_r, lon_sc_r;

  // model state, also the result register
  logic signed [23:0] yaw_rate_r, surge_r;
  logic [18:0]        heading_r;
  logic signed [31:0] lat_r;
  logic signed [32:0] lon_r;

  // item latches and temporaries
  logic [23:0]        dt_r;
  logic signed [18:0] rud_r;
  logic signed [23:0] cmd_r;
  logic signed [17:0] sa_r, ca_r, sh_r, ch_r;
  ival_t              sq_r, tmp_r, force_r, rdrag_r;
  logic signed [23:0] yr_n_r, sn_n_r;
  logic [18:0]        hd_n_r;
  logic signed [31:0] lat_n_r;
  logic signed [32:0] lon_n_r;

  ival_t              mul_a, mul_b, m;
  logic               mul_sh32, mul_done, trig_done;
  logic signed [19:0] trig_ang;
  logic signed [17:0] t_sin, t_cos;

  logic signed [49:0] yr_sum, sn_sum, lat_sum;
  logic signed [48:0] drag_sum, thr_diff;
  logic signed [20:0] dyaw, hsum, hwrap;
  logic signed [33:0] lon_c;
  logic signed [34:0] lon_sum, lon_wrap;
  logic signed [23:0] yr_sat, sn_sat;
  logic signed [31:0] lat_sat;
  ival_t              drag_sat, thr_sat;

  function automatic ival_t sx24(input logic signed [23:0] v);
    return {{24{v[23]}}, v};
  endfunction

  function automatic ival_t sx18(input logic signed [17:0] v);
    return {{30{v[17]}}, v};
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [49:0] v);
    if (v > 50'sd8388607)       return 24'sh7FFFFF;
    else if (v < -50'sd8388608) return 24'sh800000;
    else                        return v[23:0];
  endfunction

  function automatic ival_t sat48(input logic signed [48:0] v);
    if (v > LIM48)       return LIM48;
    else if (v < -LIM48) return -LIM48;
    else                 return v[47:0];
  endfunction

  // operand select
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh32 = 1'b0;
    trig_ang = {rud_r[18], rud_r};
    case (cmd.op)
      OP_TRIG_RUD: trig_ang = {rud_r[18], rud_r};
      OP_TRIG_HD:  trig_ang = {1'b0, hd_n_r};
      OP_SQ:    begin mul_a = sx24(surge_r);  mul_b = sx24(surge_r); end
      OP_T1:    begin mul_a = sq_r;           mul_b = {24'd0, area_r}; end
      OP_FORCE: begin mul_a = tmp_r;          mul_b = sx18(sa_r); end
      OP_YAWF:  begin mul_a = force_r;        mul_b = sx18(ca_r); end
      OP_RDRAG: begin mul_a = force_r;        mul_b = sx18(sa_r); end
      OP_TORQ:  begin mul_a = tmp_r;          mul_b = {24'd0, lever_r}; end
      OP_YACC:  begin mul_a = tmp_r; mul_b = {16'd0, inv_i_r}; mul_sh32 = 1'b1; end
      OP_YR:    begin mul_a = tmp_r;          mul_b = {24'd0, dt_r}; end
      OP_DYAW:  begin mul_a = sx24(yr_n_r);   mul_b = {24'd0, dt_r}; end
      OP_DRAG:  begin mul_a = {24'd0, drag_r}; mul_b = sq_r; end
      OP_THR:   begin mul_a = {24'd0, thrust_r}; mul_b = sx24(cmd_r); end
      OP_SACC:  begin mul_a = tmp_r; mul_b = {16'd0, inv_m_r}; mul_sh32 = 1'b1; end
      OP_SN:    begin mul_a = tmp_r;          mul_b = {24'd0, dt_r}; end
      OP_NC:    begin mul_a = sx24(sn_n_r);   mul_b = sx18(ch_r); end
      OP_DN:    begin mul_a = tmp_r;          mul_b = {24'd0, dt_r}; end
      OP_LAT:   begin mul_a = tmp_r; mul_b = {8'd0, lat_sc_r}; mul_sh32 = 1'b1; end
      OP_EC:    begin mul_a = sx24(sn_n_r);   mul_b = sx18(sh_r); end
      OP_DE:    begin mul_a = tmp_r;          mul_b = {24'd0, dt_r}; end
      OP_LON:   begin mul_a = tmp_r; mul_b = {8'd0, lon_sc_r}; mul_sh32 = 1'b1; end
      default: ;
    endcase
  end

  vdrs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh32  (mul_sh32),
    .done  (mul_done),
    .p     (m)
  );

  vdrs_cordic #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.trig_start),
    .angle (trig_ang),
    .done  (trig_done),
    .sin_q (t_sin),
    .cos_q (t_cos)
  );

  assign stat = {mul_done, trig_done};

  // writeback arithmetic
  always_comb begin
    yr_sum   = 50'(sx24(yaw_rate_r)) + 50'(m);
    yr_sat   = clamp24(yr_sum);
    sn_sum   = 50'(sx24(surge_r)) + 50'(m);
    sn_sat   = clamp24(sn_sum);
    drag_sum = 49'(m) + 49'(rdrag_r);
    drag_sat = sat48(drag_sum);
    thr_diff = 49'(m) - 49'(tmp_r);
    thr_sat  = sat48(thr_diff);
    // heading step limited to one turn, then one wrap correction
    if (m > 48'(TWO_PI_Q16))       dyaw = TWO_PI_Q16;
    else if (m < -48'(TWO_PI_Q16)) dyaw = -TWO_PI_Q16;
    else                           dyaw = m[20:0];
    hsum = $signed({2'b00, heading_r}) + dyaw;
    if (hsum < 21'sd0)            hwrap = hsum + TWO_PI_Q16;
    else if (hsum > TWO_PI_Q16)   hwrap = hsum - TWO_PI_Q16;
    else                          hwrap = hsum;
    lat_sum = 50'(lat_r) + 50'(m);
    if (lat_sum > 50'(DEG90_Q24))       lat_sat = DEG90_Q24[31:0];
    else if (lat_sum < -50'(DEG90_Q24)) lat_sat = 32'(-DEG90_Q24);
    else                                lat_sat = lat_sum[31:0];
    if (m > 48'(DEG360_Q24))       lon_c = DEG360_Q24;
    else if (m < -48'(DEG360_Q24)) lon_c = -DEG360_Q24;
    else                           lon_c = m[33:0];
    lon_sum = 35'(lon_r) + 35'(lon_c);
    if (lon_sum > 35'(DEG180_Q24))       lon_wrap = lon_sum - 35'(DEG360_Q24);
    else if (lon_sum < -35'(DEG180_Q24)) lon_wrap = lon_sum + 35'(DEG360_Q24);
    else                                 lon_wrap = lon_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r     <= 24'd327680;
      thrust_r   <= 24'd655360;
      inv_m_r    <= 32'd429497;
      inv_i_r    <= 32'd42949673;
      area_r     <= 24'd262144;
      lever_r    <= 24'd294912;
      lat_sc_r   <= 40'd39574975;
      lon_sc_r   <= 40'd55779544;
      yaw_rate_r <= '0;
      heading_r  <= HEADING_RESET;
      surge_r    <= '0;
      lat_r      <= LAT_RESET;
      lon_r      <= LON_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRAG_COEFF:   drag_r   <= cfg_data[23:0];
          REG_THRUST_GAIN:  thrust_r <= cfg_data[23:0];
          REG_INV_MASS:     inv_m_r  <= cfg_data[31:0];
          REG_INV_YAW_INER: inv_i_r  <= cfg_data[31:0];
          REG_RUDDER_AREA:  area_r   <= cfg_data[23:0];
          REG_LEVER_ARM:    lever_r  <= cfg_data[23:0];
          REG_LAT_SCALE:    lat_sc_r <= cfg_data;
          REG_LON_SCALE:    lon_sc_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        yaw_rate_r <= yr_n_r;
        heading_r  <= hd_n_r;
        surge_r    <= sn_n_r;
        lat_r      <= lat_n_r;
        lon_r      <= lon_n_r;
      end
    end
    if (cmd.load_in) begin
      dt_r  <= in_data[23:0];
      rud_r <= in_data[42:24];
      cmd_r <= in_data[66:43];
    end
    if (trig_done) begin
      if (cmd.op == OP_TRIG_RUD) begin
        sa_r <= t_sin;
        ca_r <= t_cos;
      end else begin
        sh_r <= t_sin;
        ch_r <= t_cos;
      end
    end
    if (mul_done) begin
      case (cmd.op)
        OP_SQ:    sq_r    <= m;
        OP_FORCE: force_r <= m;
        OP_RDRAG: rdrag_r <= m;
        OP_TORQ:  tmp_r   <= ival_t'(-m);
        OP_YR:    yr_n_r  <= yr_sat;
        OP_DYAW:  hd_n_r  <= hwrap[18:0];
        OP_DRAG:  tmp_r   <= drag_sat;
        OP_THR:   tmp_r   <= thr_sat;
        OP_SN:    sn_n_r  <= sn_sat;
        OP_LAT:   lat_n_r <= lat_sat;
        OP_LON:   lon_n_r <= lon_wrap[32:0];
        default:  tmp_r   <= m;
      endcase
    end
  end

  assign out_data = {4'd0, yaw_rate_r, surge_r, heading_r, lon_r, lat_r};
endmodule

// ----- hw/rtl/vdrs_ctrl.sv -----
module vdrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output vdrs_pkg::dp_cmd_t  cmd,
  input  vdrs_pkg::dp_stat_t stat
);
  import vdrs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   in_ready_r, in_ready_nxt, out_valid_r, out_valid_nxt;
  logic   accept, commit, is_trig;

  always_comb begin
    is_trig = (op_r == OP_TRIG_RUD) || (op_r == OP_TRIG_HD);
    accept  = in_tvalid & in_ready_r;
    // state is committed only once the previous result has been taken
    commit  = (state_r == S_DONE) && (!out_valid_r || out_tready);

    state_nxt     = state_r;
    op_nxt        = op_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = OP_TRIG_RUD;
          in_ready_nxt = 1'b0;
          state_nxt    = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (stat.mul_done || stat.trig_done) begin
          if (op_r == OP_LON) begin
            state_nxt = S_DONE;
          end else begin
            op_nxt    = op_t'(op_r + 5'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        if (commit) begin
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    cmd.op         = op_r;
    cmd.mul_start  = (state_r == S_ISSUE) && !is_trig;
    cmd.trig_start = (state_r == S_ISSUE) && is_trig;
    cmd.load_in    = accept;
    cmd.commit     = commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TRIG_RUD;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready_r)
    else $error("input still ready after a transfer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.mul_done && stat.trig_done))
    else $error("multiplier and trig unit finished together");
endmodule

// ----- hw/rtl/vessel_dead_reckoning_step_core.sv -----
// Dead-reckoning step for a surface vessel: each input transfer (time step,
// rudder angle, thrust command) advances yaw rate, heading, surge speed,
// latitude and longitude by one forward-Euler step and yields one result
// transfer with the updated state. One item is in work at a time: the next
// input is taken only after the state of the last one is committed. A
// sequencer runs 19 rounded products through one shared 48x16 multiplier
// and two sine/cosine evaluations through one 20-iteration CORDIC, then
// commits the state. While a result waits, the next item is accepted and
// computed; its update is committed only once the waiting result has been
// taken, and the sequencer stalls until then. Configuration writes are
// always ready and take effect at once, so write registers only while no
// item is in work.
module vessel_dead_reckoning_step_core #(
  parameter int TRIG_TABLE_BITS = vdrs_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // time_step[23:0], helm_angle[42:24], thrust_command[66:43]
  input  logic [vdrs_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // latitude[31:0], longitude[64:32], heading[83:65], surge_speed[107:84],
  // yaw_rate[131:108]
  output logic [vdrs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vdrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vdrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vdrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vdrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  vdrs_dp #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );
endmodule

// ----- dv/vessel_dead_reckoning_step_core_tb.sv -----
module vessel_dead_reckoning_step_core_tb;
  import vdrs_pkg::*;

  localparam int  IDLE_LIMIT = 5000;
  localparam int  DRAIN_CYCLES = 250;
  localparam int  NUM_RANDOM = 1280;
  localparam longint SAT48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint SPD_MAX = 8388607;
  localparam longint SPD_MIN = -8388608;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [32:0] lon;
    logic [18:0]        hdg;
    logic signed [23:0] surge;
    logic signed [23:0] yaw_rate;
  } nav_fix_t;

  class nav_scoreboard;
    longint unsigned regs[8];
    longint yaw_rate_s, heading_s, surge_s, lat_s, lon_s;
    nav_fix_t expected_fixes[$];
    int errors;
    int fixes_seen;
    longint cordic_atan[CORDIC_STEPS];

    function void init();
      longint unsigned defaults[8] = '{327680, 655360, 429497, 42949673, 262144,
                                       294912, 39574975, 55779544};
      cordic_atan = '{536870912, 316933406, 167458907, 85004756, 42667331,
                      21354465, 10680862, 5340245, 2670163, 1335087, 667544,
                      333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304};
      regs = defaults;
      yaw_rate_s = 0;
      heading_s = longint'(HEADING_RESET);
      surge_s = 0;
      lat_s = longint'(LAT_RESET);
      lon_s = longint'(LON_RESET);
      errors = 0;
      fixes_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DRAG_COEFF, REG_THRUST_GAIN, REG_RUDDER_AREA, REG_LEVER_ARM:
          regs[idx] = val[23:0];
        REG_INV_MASS, REG_INV_YAW_INER: regs[idx] = val[31:0];
        REG_LAT_SCALE, REG_LON_SCALE:   regs[idx] = val[39:0];
        default: ;
      endcase
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rounded a*b / 2^sh, ties away from zero, saturated to 48 bits
    static function longint mul_round(longint a, longint b, int sh);
      logic [127:0] ua, ub, p;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = (ua * ub + (128'd1 << (sh - 1))) >> sh;
      if (p > 128'(SAT48)) p = 128'(SAT48);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    static function longint to_q16(longint v);
      return clip((v + 8192) >>> 14, -65536, 65536);
    endfunction

    function void sin_cos(longint ang, output longint sn, output longint cs);
      logic [63:0] prod;
      logic [31:0] turns, k, phase;
      longint x, y, z, dx, dy;
      bit flip;
      prod = ang * 64'sd683565276;
      turns = prod[47:16];
      k = turns + (32'd1 << (31 - TRIG_TABLE_BITS_DEF));
      phase = (k >> (32 - TRIG_TABLE_BITS_DEF)) << (32 - TRIG_TABLE_BITS_DEF);
      flip = phase[31:30] == 2'd1 || phase[31:30] == 2'd2;
      if (flip) phase = phase - 32'h8000_0000;
      z = longint'(int'(phase));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= cordic_atan[i];
        end else begin
          x += dx; y -= dy; z += cordic_atan[i];
        end
      end
      sn = to_q16(y);
      cs = to_q16(x);
      if (flip) begin
        sn = -sn;
        cs = -cs;
      end
    endfunction

    function void note_step(logic [IN_DATA_W-1:0] d);
      longint dt, rud, cmd, sa, ca, sh, ch, sq, force_r, yawf, rdrag, torque, yacc;
      longint yr, dyaw, hd, total, net, sacc, sn, dn, de, lat, lon;
      nav_fix_t f;
      dt = longint'(d[23:0]);
      rud = longint'($signed(d[42:24]));
      cmd = longint'($signed(d[66:43]));
      sin_cos(rud, sa, ca);
      sq = mul_round(surge_s, surge_s, 16);
      force_r = mul_round(mul_round(sq, longint'(regs[4]), 16), sa, 16);
      yawf = mul_round(force_r, ca, 16);
      rdrag = mul_round(force_r, sa, 16);
      torque = -mul_round(yawf, longint'(regs[5]), 16);
      yacc = mul_round(torque, longint'(regs[3]), 32);
      yr = clip(yaw_rate_s + mul_round(yacc, dt, 16), SPD_MIN, SPD_MAX);
      dyaw = clip(mul_round(yr, dt, 16), -411775, 411775);
      hd = heading_s + dyaw;
      if (hd < 0) hd += 411775;
      else if (hd > 411775) hd -= 411775;
      total = clip(mul_round(longint'(regs[0]), sq, 16) + rdrag, -SAT48, SAT48);
      net = clip(mul_round(longint'(regs[1]), cmd, 16) - total, -SAT48, SAT48);
      sacc = mul_round(net, longint'(regs[2]), 32);
      sn = clip(surge_s + mul_round(sacc, dt, 16), SPD_MIN, SPD_MAX);
      sin_cos(hd, sh, ch);
      dn = mul_round(mul_round(sn, ch, 16), dt, 16);
      de = mul_round(mul_round(sn, sh, 16), dt, 16);
      lat = clip(lat_s + mul_round(dn, longint'(regs[6]), 32),
                 -longint'(DEG90_Q24), longint'(DEG90_Q24));
      lon = lon_s + clip(mul_round(de, longint'(regs[7]), 32),
                         -longint'(DEG360_Q24), longint'(DEG360_Q24));
      if (lon > longint'(DEG180_Q24)) lon -= longint'(DEG360_Q24);
      else if (lon < -longint'(DEG180_Q24)) lon += longint'(DEG360_Q24);
      yaw_rate_s = yr;
      heading_s = hd;
      surge_s = sn;
      lat_s = lat;
      lon_s = lon;
      f.lat = lat[31:0];
      f.lon = lon[32:0];
      f.hdg = hd[18:0];
      f.surge = sn[23:0];
      f.yaw_rate = yr[23:0];
      expected_fixes.push_back(f);
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch on fix %0d, %s: got %0d, expected %0d",
               fixes_seen, field, got, want);
      errors++;
    endtask

    task check_fix(logic [OUT_DATA_W-1:0] d);
      nav_fix_t w;
      fixes_seen++;
      if (expected_fixes.size() == 0) begin
        $display("unexpected fix transfer %0d", fixes_seen);
        errors++;
        return;
      end
      w = expected_fixes.pop_front();
      if ($signed(d[31:0]) != w.lat) report("latitude", $signed(d[31:0]), w.lat);
      if ($signed(d[64:32]) != w.lon) report("longitude", $signed(d[64:32]), w.lon);
      if (d[83:65] != w.hdg) report("heading", d[83:65], w.hdg);
      if ($signed(d[107:84]) != w.surge)
        report("surge_speed", $signed(d[107:84]), w.surge);
      if ($signed(d[131:108]) != w.yaw_rate)
        report("yaw_rate", $signed(d[131:108]), w.yaw_rate);
    endtask
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic hold_off;

  nav_scoreboard sb;
  int steps_sent, burst_left, idle_cycles, rx_mode, rx_count, cfg_writes;

  vessel_dead_reckoning_step_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_step(in_tdata);
    if (out_tvalid && out_tready) sb.check_fix(out_tdata);
    if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // receiver stall pattern, in one of four modes drawn at random
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= !hold_off;
      1: out_tready <= !hold_off && $urandom_range(0, 1);
      2: out_tready <= !hold_off && ($urandom_range(0, 9) == 0);
      default: out_tready <= !hold_off && ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 0;
    wait (steps_sent >= 300);
    @(posedge clk);
    hold_off <= 1;
    repeat (1500) @(posedge clk);
    hold_off <= 0;
  end

  task send_step(logic [23:0] dt, logic [18:0] rud, logic [23:0] cmd);
    in_tvalid <= 1;
    in_tdata <= {5'b0, cmd, rud, dt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    steps_sent++;
    if (--burst_left <= 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task settle();
    in_tvalid <= 0;
    cfg_valid <= 0;
    @(posedge clk);
    while (sb.expected_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // 1 moderate random, 2 all ones, 3 all zeros, any other kind full random
  task load_config(int kind);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        1: v = CFG_DATA_W'({$urandom, $urandom})
               & ((i == 6 || i == 7) ? 40'hFF_FFFF_FFF : 40'hFF_FFFF);
        2: v = '1;
        3: v = '0;
        default: v = CFG_DATA_W'({$urandom, $urandom});
      endcase
      write_reg(i[CFG_IDX_W-1:0], v);
    end
    write_reg(8'd8 + CFG_IDX_W'($urandom_range(0, 247)),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 0;
  endtask

  task random_step();
    logic [23:0] dt, cmd;
    logic [18:0] rud;
    case ($urandom_range(0, 9))
      0: dt = 0;
      1, 2: dt = 24'($urandom);
      default: dt = 24'($urandom_range(0, 131072));
    endcase
    rud = ($urandom_range(0, 4) == 0) ? 19'($urandom)
                                      : 19'($signed($urandom_range(0, 411774)) - 205887);
    cmd = ($urandom_range(0, 2) == 0) ? 24'($signed($urandom_range(0, 2000000)) - 1000000)
                                      : 24'($urandom);
    send_step(dt, rud, cmd);
  endtask

  initial begin
    sb = new();
    sb.init();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    out_tready = 0;
    rx_mode = 0;
    rx_count = 0;
    idle_cycles = 0;
    steps_sent = 0;
    cfg_writes = 0;
    burst_left = 3;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: build up speed, then rudder and field extremes
    send_step(24'd65536, 19'd0, 24'h7FFFFF);
    send_step(24'd65536, 19'd0, 24'h7FFFFF);
    send_step(24'd0, 19'd205887, 24'h123456);
    send_step(24'd32768, 19'd205887, 24'd0);
    send_step(24'd32768, -19'sd205887, 24'd0);
    send_step(24'd65536, 19'h3FFFF, 24'h800000);
    send_step(24'd65536, 19'h40000, 24'h800000);
    send_step(24'hFFFFFF, 19'd102944, 24'h7FFFFF);
    send_step(24'hFFFFFF, -19'sd102944, 24'h800000);
    send_step(24'hFFFFFF, 19'h7FFFF, 24'hFFFFFF);
    send_step(24'd1, 19'd51472, 24'd1);
    send_step(24'hFFFFFF, 19'd205887, 24'h7FFFFF);
    send_step(24'hFFFFFF, -19'sd205887, 24'h7FFFFF);
    send_step(24'd0, 19'd0, 24'd0);
    settle();
    load_config(2);
    for (int i = 0; i < 10; i++) random_step();
    send_step(24'hFFFFFF, 19'd205887, 24'h7FFFFF);
    send_step(24'hFFFFFF, -19'sd205887, 24'h800000);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      load_config(ph == 0 ? 1 : ph == 1 ? 3 : ph == 2 ? 4 : ph == 3 ? 0 : 1);
      for (int i = 0; i < NUM_RANDOM / 6; i++) random_step();
      settle();
    end

    $display("%0d steps checked over 8 register settings (%0d register writes),",
             sb.fixes_seen, cfg_writes);
    $display("including all-zero and all-ones registers and a long output stall");
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
